// File: rtl/dedup_packet_fifo_with_range_count_macros.svh
// ----------------------------------------------------------------------------
// dedup packet fifo assertion macros
// shared concurrent assertion forms for the packet buffer rtl
// ----------------------------------------------------------------------------
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_MACROS_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_MACROS_SVH

// checked on every clock edge outside reset
`define DPF_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// checked on every clock edge, reset included
`define DPF_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: rtl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// types and codes shared by the packet buffer cells, scan unit and top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpf_pkg;

  // operation codes carried on the input tuser
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_FWD = 2'd1;
  localparam logic [1:0] FUNC_CNT = 2'd2;

  // count result width and saturation value
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // limit register
  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // one stored packet
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] dst;
    logic [15:0] src;
  } entry_t;

  // per-cycle control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
    logic occupied;
    logic head;
  } scan_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// File: rtl/dedup_packet_fifo_with_range_count.sv
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count
// bounded packet buffer with duplicate rejection, forward of the oldest
// packet and a count by destination over a time window
// ----------------------------------------------------------------------------
// Usage: one command word enters on s_*, tuser carries the operation (add,
// forward, count), tdata the packet and the count window. Exactly one result
// word leaves on m_* per command. The user must write the limit register on
// cfg_* only while the block is idle; the block itself does not enforce it.
// Values of 0 act as 1, values above DEPTH act as DEPTH.
// The packets sit in a ring of DEPTH cells. Every add, forward and count
// rotates the ring once through the tap unit, one cell per cycle. After the
// scan come the decide and done states; an add that is no duplicate also
// passes evict and write between them, and an unused code goes straight to
// done. From done the block returns to idle before it takes the next command.
// The result sits in its own register, so the next command is taken while
// an earlier result still waits; a stalled receiver only holds the block
// once a second result is ready. Reset empties the buffer at once (no
// clearing pass), sets the limit to 64 and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dedup_packet_fifo_with_range_count_macros.svh"

module dedup_packet_fifo_with_range_count
  import dpf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  // command word
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: source, destination, timestamp, start_time, end_time
  input  logic [127:0] s_tdata,
  // tuser: func
  input  logic [1:0]   s_tuser,
  // result word
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: added, fwd_source, fwd_destination, fwd_timestamp, match_count
  output logic [71:0]  m_tdata,
  // tuser: fwd_valid
  output logic [0:0]   m_tuser,
  // limit register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  state_t state, state_next;

  logic [PW-1:0]      oldest_pointer;
  logic [CW-1:0]      fill;
  logic [PW-1:0]      scan_idx;
  logic [PW-1:0]      off;
  logic [LIMIT_W-1:0] memory_limit;
  logic [CW-1:0]      lim;
  logic [CW-1:0]      drop;
  logic [PW-1:0]      slot;
  logic               added_flag;
  logic               fwd_hit;
  logic               out_free;
  logic               accept;

  // request holding registers
  logic [1:0]  req_func;
  entry_t      req_entry;
  logic [31:0] req_t0;
  logic [31:0] req_t1;

  // ring and tap
  entry_t            cell_q [DEPTH];
  logic [DEPTH-1:0]  cell_load;
  logic              ring_shift;
  scan_ctl_t         scan_ctl;
  logic              scan_dup;
  logic [COUNT_W-1:0] scan_count;
  entry_t            scan_head;

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] v);
    if (v >= SW'(DEPTH)) begin
      return PW'(v - SW'(DEPTH));
    end else begin
      return PW'(v);
    end
  endfunction

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = !rst;

  // clamped limit
  always_comb begin
    if (memory_limit == '0) begin
      lim = CW'(1);
    end else if (LW'(memory_limit) > LW'(DEPTH)) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(LW'(memory_limit));
    end
  end

  assign drop = fill - (lim - CW'(1));
  assign slot = wrap(SW'(oldest_pointer) + SW'(fill));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((s_tuser == FUNC_ADD) || (s_tuser == FUNC_FWD) || (s_tuser == FUNC_CNT)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx == LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if ((req_func == FUNC_ADD) && !scan_dup) begin
          state_next = ST_EVICT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_EVICT: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready          = 1'b0;
    ring_shift        = 1'b0;
    scan_ctl          = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready       = !rst;
        scan_ctl.clear = accept;
      end
      ST_SCAN: begin
        ring_shift        = 1'b1;
        scan_ctl.step     = 1'b1;
        scan_ctl.occupied = CW'(off) < fill;
        scan_ctl.head     = (off == '0) && (fill != '0);
      end
      default: begin
      end
    endcase
  end

  // write decode, one load strobe per cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_load[i] = (state == ST_WRITE) && (slot == PW'(i));
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state: pointers, fill, limit, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_pointer <= '0;
      fill           <= '0;
      memory_limit   <= LIMIT_RESET;
      added_flag     <= 1'b0;
      fwd_hit        <= 1'b0;
      scan_idx       <= '0;
      off            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        memory_limit <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            added_flag <= 1'b0;
            fwd_hit    <= 1'b0;
            scan_idx   <= '0;
            off        <= (oldest_pointer == '0) ? '0 :
                          PW'(SW'(DEPTH) - SW'(oldest_pointer));
          end
        end
        ST_SCAN: begin
          scan_idx <= (scan_idx == LAST) ? '0 : scan_idx + 1'b1;
          off      <= (off == LAST) ? '0 : off + 1'b1;
        end
        ST_DECIDE: begin
          // forward drops the oldest entry
          if ((req_func == FUNC_FWD) && (fill != '0)) begin
            fwd_hit        <= 1'b1;
            oldest_pointer <= wrap(SW'(oldest_pointer) + SW'(1));
            fill           <= fill - 1'b1;
          end
        end
        ST_EVICT: begin
          if (fill >= lim) begin
            oldest_pointer <= wrap(SW'(oldest_pointer) + SW'(drop));
            fill           <= lim - CW'(1);
          end
        end
        ST_WRITE: begin
          fill       <= fill + 1'b1;
          added_flag <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // latch the command word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func        <= s_tuser;
      req_entry.src   <= s_tdata[15:0];
      req_entry.dst   <= s_tdata[31:16];
      req_entry.stamp <= s_tdata[63:32];
      req_t0          <= s_tdata[95:64];
      req_t1          <= s_tdata[127:96];
    end
  end

  // ring of cells, rotating toward cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dpf_cell u_cell (
      .clk      (clk),
      .shift    (ring_shift),
      .load     (cell_load[g]),
      .shift_in (cell_q[(g + 1) % DEPTH]),
      .load_in  (req_entry),
      .q        (cell_q[g])
    );
  end

  dpf_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .tap        (cell_q[0]),
    .query      (req_entry),
    .start_time (req_t0),
    .end_time   (req_t1),
    .dup        (scan_dup),
    .count      (scan_count),
    .head       (scan_head)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata[0]     <= added_flag;
      m_tdata[16:1]  <= fwd_hit ? scan_head.src : 16'd0;
      m_tdata[32:17] <= fwd_hit ? scan_head.dst : 16'd0;
      m_tdata[64:33] <= fwd_hit ? scan_head.stamp : 32'd0;
      m_tdata[71:65] <= (req_func == FUNC_CNT) ? scan_count : '0;
      m_tuser[0]     <= fwd_hit;
    end
  end

  // checks
  `DPF_ASSERT(a_fill_bound, clk, rst, (fill <= CW'(DEPTH)), "fill above depth")
  `DPF_ASSERT(a_ptr_bound, clk, rst, (oldest_pointer <= LAST), "oldest pointer out of range")
  `DPF_ASSERT(a_evict_room, clk, rst, (state == ST_EVICT) |=> (fill < CW'(DEPTH)),
              "no room after evict")
  `DPF_ASSERT(a_scan_end, clk, rst,
              (state == ST_SCAN && scan_idx == LAST) |=> (state == ST_DECIDE),
              "scan overran the ring")
  `DPF_ASSERT(a_accept_go, clk, rst, accept |=> (state == ST_SCAN || state == ST_DONE),
              "command not started")
  `DPF_ASSERT_ALWAYS(a_ready_idle, clk, (s_tready == ((state == ST_IDLE) && !rst)),
                     "ready outside idle")

endmodule

// File: rtl/dpf_cell.sv
// ----------------------------------------------------------------------------
// dpf_cell
// one storage cell of the packet ring: loads a new packet or takes its
// neighbor's packet when the ring rotates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpf_cell
  import dpf_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  logic   load,
  input  entry_t shift_in,
  input  entry_t load_in,
  output entry_t q
);

  entry_t held;

  // payload storage, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_in;
    end else if (shift) begin
      held <= shift_in;
    end
  end

  assign q = held;

endmodule

// File: rtl/dpf_scan.sv
// ----------------------------------------------------------------------------
// dpf_scan
// tap unit at the head of the ring: duplicate check, range count and
// capture of the oldest packet, one stored entry per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpf_scan
  import dpf_pkg::*;
(
  input  logic               clk,
  input  scan_ctl_t          ctl,
  input  entry_t             tap,
  input  entry_t             query,
  input  logic [31:0]        start_time,
  input  logic [31:0]        end_time,
  output logic               dup,
  output logic [COUNT_W-1:0] count,
  output entry_t             head
);

  logic hit_dup;
  logic hit_range;

  // compares against the entry under the tap
  assign hit_dup   = ctl.occupied && (tap == query);
  assign hit_range = ctl.occupied && (tap.dst == query.dst) &&
                     (tap.stamp >= start_time) && (tap.stamp <= end_time);

  // accumulate over the scan
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      dup   <= 1'b0;
      count <= '0;
    end else if (ctl.step) begin
      if (hit_dup) begin
        dup <= 1'b1;
      end
      if (hit_range && (count != COUNT_MAX)) begin
        count <= count + 1'b1;
      end
    end
  end

  // grab the oldest packet as it passes the tap
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.head) begin
      head <= tap;
    end
  end

endmodule
